FILE: hw/rtl/nectx_pkg.sv
// ----------------------------------------------------------------------------
// nectx_pkg
// Shared constants, types and helpers for the NEC IR frame transmitter.
// ----------------------------------------------------------------------------
package nectx_pkg;

   // Interval counter width and configuration register width
   localparam int COUNT_WIDTH = 24;
   localparam int CFG_WIDTH   = 24;
   localparam int CSR_IDX_W   = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_MARK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_SPACE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT         = 2'd2;

   // Reset values of the timing registers
   localparam logic [CFG_WIDTH-1:0] RST_LEADER_MARK  = 24'd360000;
   localparam logic [CFG_WIDTH-1:0] RST_LEADER_SPACE = 24'd180000;
   localparam logic [CFG_WIDTH-1:0] RST_UNIT         = 24'd22720;

   // Frame slots
   localparam int SLOT_W = 3;
   localparam logic [SLOT_W-1:0] SLOT_MARK      = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_SPACE     = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_ADDR      = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_ADDR_INV  = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_DATA      = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_DATA_INV  = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_BURST     = 3'd6;

   // Request kinds (req_tuser)
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   // Timing registers as seen by the frame engine
   typedef struct packed {
      logic [CFG_WIDTH-1:0] leader_mark;
      logic [CFG_WIDTH-1:0] leader_space;
      logic [CFG_WIDTH-1:0] unit;
   } timing_cfg_type;

   // One result item, ir_gate in the lowest bit
   typedef struct packed {
      logic start_rejected;
      logic frame_done;
      logic busy_res;
      logic ir_gate;
   } result_type;

   localparam int RSP_DATA_W = 8;
   localparam int RESULT_W   = $bits(result_type);

   // Byte sent in a given byte slot
   function automatic logic [7:0] byte_for_slot(input logic [SLOT_W-1:0] slot,
                                                input logic [7:0] address,
                                                input logic [7:0] data);
      logic [7:0] b;
      case (slot)
         SLOT_ADDR:     b = address;
         SLOT_ADDR_INV: b = ~address;
         SLOT_DATA:     b = data;
         default:       b = ~data;
      endcase
      return b;
   endfunction

endpackage

FILE: hw/rtl/nectx_engine.sv
// ----------------------------------------------------------------------------
// nectx_engine
// Frame sequencer: updates the frame state once per accepted transaction and
// presents the result of that transaction combinationally.
// ----------------------------------------------------------------------------
module nectx_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     req_kind,
   input  logic [7:0]               frame_address,
   input  logic [7:0]               frame_data,
   input  nectx_pkg::timing_cfg_type cfg,
   output nectx_pkg::result_type    result
);

   logic [nectx_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic [nectx_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [7:0]                        shift_ff, shift_in;
   logic [2:0]                        bitpos_ff, bitpos_in;
   logic                              cur_bit_ff, cur_bit_in;
   logic [1:0]                        units_ff, units_in;
   logic [7:0]                        addr_ff, addr_in;
   logic [7:0]                        data_ff, data_in;
   logic                              gate_ff, gate_in;
   logic                              active_ff, active_in;
   logic                              done, rejected;

   logic [7:0]                        shifted;
   logic [2:0]                        bitpos_next;
   logic [nectx_pkg::SLOT_W-1:0]      slot_next;
   logic [7:0]                        next_byte;
   logic [1:0]                        last_unit;

   assign shifted     = {shift_ff[6:0], 1'b0};
   assign bitpos_next = bitpos_ff + 3'd1;
   assign slot_next   = slot_ff + 3'd1;
   assign next_byte   = nectx_pkg::byte_for_slot(slot_next, addr_ff, data_ff);
   assign last_unit   = cur_bit_ff ? 2'd3 : 2'd1;

   // Next-state logic for one transaction
   always_comb begin
      slot_in    = slot_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      bitpos_in  = bitpos_ff;
      cur_bit_in = cur_bit_ff;
      units_in   = units_ff;
      addr_in    = addr_ff;
      data_in    = data_ff;
      gate_in    = gate_ff;
      active_in  = active_ff;
      done       = 1'b0;
      rejected   = 1'b0;

      if (req_kind == nectx_pkg::REQ_START) begin
         if (active_ff) begin
            rejected = 1'b1;
         end else begin
            addr_in    = frame_address;
            data_in    = frame_data;
            active_in  = 1'b1;
            slot_in    = nectx_pkg::SLOT_MARK;
            shift_in   = 8'd0;
            bitpos_in  = 3'd0;
            cur_bit_in = 1'b0;
            units_in   = 2'd0;
            count_in   = nectx_pkg::COUNT_WIDTH'(cfg.leader_mark);
            gate_in    = 1'b1;
         end
      end else if (active_ff) begin
         if (count_ff > nectx_pkg::COUNT_WIDTH'(1)) begin
            count_in = count_ff - nectx_pkg::COUNT_WIDTH'(1);
         end else if (slot_ff == nectx_pkg::SLOT_MARK) begin
            slot_in  = nectx_pkg::SLOT_SPACE;
            count_in = nectx_pkg::COUNT_WIDTH'(cfg.leader_space);
            gate_in  = 1'b0;
         end else if (slot_ff == nectx_pkg::SLOT_SPACE) begin
            slot_in    = nectx_pkg::SLOT_ADDR;
            shift_in   = next_byte;
            bitpos_in  = 3'd0;
            cur_bit_in = next_byte[7];
            units_in   = 2'd0;
            count_in   = nectx_pkg::COUNT_WIDTH'(cfg.unit);
            gate_in    = 1'b1;
         end else if (slot_ff >= nectx_pkg::SLOT_BURST) begin
            // final burst over: frame ends
            slot_in   = nectx_pkg::SLOT_MARK;
            count_in  = '0;
            gate_in   = 1'b0;
            active_in = 1'b0;
            done      = 1'b1;
         end else if (units_ff != last_unit) begin
            // off units of the current bit
            units_in = units_ff + 2'd1;
            count_in = nectx_pkg::COUNT_WIDTH'(cfg.unit);
            gate_in  = 1'b0;
         end else begin
            // bit finished
            shift_in  = shifted;
            bitpos_in = bitpos_next;
            units_in  = 2'd0;
            count_in  = nectx_pkg::COUNT_WIDTH'(cfg.unit);
            gate_in   = 1'b1;
            if (bitpos_next != 3'd0) begin
               cur_bit_in = shifted[7];
            end else if (slot_ff == nectx_pkg::SLOT_DATA_INV) begin
               slot_in = nectx_pkg::SLOT_BURST;
            end else begin
               slot_in    = slot_next;
               shift_in   = next_byte;
               cur_bit_in = next_byte[7];
            end
         end
      end
   end

   // Result of this transaction reflects the updated state
   always_comb begin
      result.ir_gate        = gate_in;
      result.busy_res       = active_in;
      result.frame_done     = done;
      result.start_rejected = rejected;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= nectx_pkg::SLOT_MARK;
         count_ff   <= '0;
         shift_ff   <= 8'd0;
         bitpos_ff  <= 3'd0;
         cur_bit_ff <= 1'b0;
         units_ff   <= 2'd0;
         addr_ff    <= 8'd0;
         data_ff    <= 8'd0;
         gate_ff    <= 1'b0;
         active_ff  <= 1'b0;
      end else if (step) begin
         slot_ff    <= slot_in;
         count_ff   <= count_in;
         shift_ff   <= shift_in;
         bitpos_ff  <= bitpos_in;
         cur_bit_ff <= cur_bit_in;
         units_ff   <= units_in;
         addr_ff    <= addr_in;
         data_ff    <= data_in;
         gate_ff    <= gate_in;
         active_ff  <= active_in;
      end
   end

endmodule

FILE: hw/rtl/nec_ir_frame_transmitter.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_transmitter
// NEC-style IR frame transmitter driving a carrier gate, one result per
// request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Each req transaction is one time step. req_tuser = 0 means one clock tick
//   passes; req_tuser = 1 starts a frame with the address and data bytes in
//   req_tdata (ignored and flagged start_rejected while a frame is running).
//   Every request yields exactly one rsp transaction carrying ir_gate,
//   busy_res, frame_done and start_rejected after that step.
//   Timing registers (leader mark, leader space, unit length, in ticks) are
//   written through csr_we / csr_index / csr_wdata; index 3 is ignored.
// Throughput:
//   One request is accepted every cycle while the skid entry is empty; the
//   frame state update is a single combinational pass (24-bit compare and
//   decrement) into the state flops.
// Reset:
//   Synchronous reset idles the sequencer with the gate off, empties the
//   output stages and loads the timing registers with 360000/180000/22720.
// Stall:
//   An output register plus one skid entry absorb a stalled receiver;
//   req_tready drops only when both hold results.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,  // [7:0] frame_address, [15:8] frame_data
   input  logic                               req_tuser,  // [0] req_type
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [nectx_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [0] ir_gate, [1] busy_res,
                                                          // [2] frame_done, [3] start_rejected
   // configuration
   input  logic                               csr_we,
   input  logic [nectx_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nectx_pkg::CFG_WIDTH-1:0]    csr_wdata
);

   nectx_pkg::timing_cfg_type cfg_ff;
   nectx_pkg::result_type     result;
   nectx_pkg::result_type     out_data_ff, out_data_in;
   nectx_pkg::result_type     skid_data_ff, skid_data_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   logic                      req_accept;
   logic                      rsp_take;

   assign req_tready = ~skid_valid_ff;
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_take   = out_valid_ff & rsp_tready;
   assign rsp_tdata  = {{(nectx_pkg::RSP_DATA_W - nectx_pkg::RESULT_W){1'b0}}, out_data_ff};

   // Timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_mark  <= nectx_pkg::RST_LEADER_MARK;
         cfg_ff.leader_space <= nectx_pkg::RST_LEADER_SPACE;
         cfg_ff.unit         <= nectx_pkg::RST_UNIT;
      end else if (csr_we) begin
         unique case (csr_index)
            nectx_pkg::CSR_LEADER_MARK:  cfg_ff.leader_mark  <= csr_wdata;
            nectx_pkg::CSR_LEADER_SPACE: cfg_ff.leader_space <= csr_wdata;
            nectx_pkg::CSR_UNIT:         cfg_ff.unit         <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame sequencer
   nectx_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (req_accept),
      .req_kind      (req_tuser),
      .frame_address (req_tdata[7:0]),
      .frame_data    (req_tdata[15:8]),
      .cfg           (cfg_ff),
      .result        (result)
   );

   // Output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_accept;
            out_data_in  = result;
         end
      end else if (req_accept) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NEC IR frame transmitter. Every request
// transaction (clock tick or frame start) is run through a cycle-accurate
// frame predictor. The predicted gate, busy, done and reject flags are then
// compared with each result transaction in order. Timing registers are
// reprogrammed between phases, sometimes while a frame is in flight. The
// sender and the receiver idle in several patterns.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // unmapped register slot, writes must be dropped
   localparam logic [nectx_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 230;
   localparam int DRAIN_LIMIT     = 20000;

   // -------------------------------------------------------------------------
   // Frame predictor and store of expected results
   // -------------------------------------------------------------------------
   class nec_frame_scoreboard;
      logic [nectx_pkg::CFG_WIDTH-1:0]   mark_len, space_len, unit_len;
      logic [nectx_pkg::SLOT_W-1:0]      slot;
      logic [nectx_pkg::COUNT_WIDTH-1:0] countdown;
      logic [7:0]                        shifter, address, data;
      logic [2:0]                        bit_pos;
      logic [1:0]                        units;
      logic                              cur_bit, gate, busy;
      nectx_pkg::result_type             expected_q[$];
      int                                checked, mismatches, frames, rejects;

      function new();
         mark_len   = nectx_pkg::RST_LEADER_MARK;
         space_len  = nectx_pkg::RST_LEADER_SPACE;
         unit_len   = nectx_pkg::RST_UNIT;
         slot       = nectx_pkg::SLOT_MARK;
         countdown  = '0;
         shifter    = '0;
         address    = '0;
         data       = '0;
         bit_pos    = '0;
         units      = '0;
         cur_bit    = 1'b0;
         gate       = 1'b0;
         busy       = 1'b0;
         checked    = 0;
         mismatches = 0;
         frames     = 0;
         rejects    = 0;
      endfunction

      function void load_interval(logic [nectx_pkg::CFG_WIDTH-1:0] len, logic level);
         countdown = nectx_pkg::COUNT_WIDTH'(len);
         gate      = level;
      endfunction

      // mark unit of a new bit, bit value taken from the shifter MSB
      function void start_bit();
         cur_bit = shifter[7];
         units   = '0;
         load_interval(unit_len, 1'b1);
      endfunction

      // address, ~address, data, ~data in slot order
      function void start_byte();
         logic [7:0] b;
         b = (slot == nectx_pkg::SLOT_ADDR || slot == nectx_pkg::SLOT_ADDR_INV) ?
             address : data;
         shifter = (slot == nectx_pkg::SLOT_ADDR || slot == nectx_pkg::SLOT_DATA) ?
                   b : ~b;
         bit_pos = '0;
         start_bit();
      endfunction

      // interval expired: step to the next one, returns 1 at end of frame
      function logic advance_interval();
         if (slot == nectx_pkg::SLOT_MARK) begin
            slot = nectx_pkg::SLOT_SPACE;
            load_interval(space_len, 1'b0);
            return 1'b0;
         end
         if (slot == nectx_pkg::SLOT_SPACE) begin
            slot = nectx_pkg::SLOT_ADDR;
            start_byte();
            return 1'b0;
         end
         if (slot >= nectx_pkg::SLOT_BURST) begin
            slot      = nectx_pkg::SLOT_MARK;
            countdown = '0;
            gate      = 1'b0;
            busy      = 1'b0;
            return 1'b1;
         end
         // space units of the current bit: one for a 0, three for a 1
         if (units != (cur_bit ? 2'd3 : 2'd1)) begin
            units = units + 2'd1;
            load_interval(unit_len, 1'b0);
            return 1'b0;
         end
         shifter = shifter << 1;
         bit_pos = bit_pos + 3'd1;
         if (bit_pos != 3'd0) begin
            start_bit();
            return 1'b0;
         end
         slot = slot + 1'b1;
         if (slot == nectx_pkg::SLOT_BURST) begin
            units = '0;
            load_interval(unit_len, 1'b1);
            return 1'b0;
         end
         start_byte();
         return 1'b0;
      endfunction

      function void note_config(logic [nectx_pkg::CSR_IDX_W-1:0] idx,
                                logic [nectx_pkg::CFG_WIDTH-1:0] value);
         case (idx)
            nectx_pkg::CSR_LEADER_MARK:  mark_len  = value;
            nectx_pkg::CSR_LEADER_SPACE: space_len = value;
            nectx_pkg::CSR_UNIT:         unit_len  = value;
            default: ;
         endcase
      endfunction

      // accepted request transaction: predict its result
      function void note_request(logic kind, logic [15:0] payload);
         nectx_pkg::result_type r;
         r = '0;
         if (kind == nectx_pkg::REQ_START) begin
            if (busy) begin
               r.start_rejected = 1'b1;
               rejects++;
            end else begin
               address = payload[7:0];
               data    = payload[15:8];
               busy    = 1'b1;
               slot    = nectx_pkg::SLOT_MARK;
               shifter = '0;
               bit_pos = '0;
               cur_bit = 1'b0;
               units   = '0;
               load_interval(mark_len, 1'b1);
            end
         end else if (busy) begin
            // a zero length reloads as zero and expires on the next tick
            if (countdown > nectx_pkg::COUNT_WIDTH'(1))
               countdown = countdown - nectx_pkg::COUNT_WIDTH'(1);
            else
               r.frame_done = advance_interval();
         end
         r.ir_gate  = gate;
         r.busy_res = busy;
         if (r.frame_done)
            frames++;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            mismatches++;
         end
      endfunction

      // accepted result transaction: compare with the oldest expectation
      function void check_result(logic [nectx_pkg::RSP_DATA_W-1:0] tdata);
         nectx_pkg::result_type want, got;
         if (expected_q.size() == 0) begin
            $error("result transaction %0h with nothing expected", tdata);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         got  = nectx_pkg::result_type'(tdata[nectx_pkg::RESULT_W-1:0]);
         compare_field("ir_gate", 8'(want.ir_gate), 8'(got.ir_gate));
         compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         compare_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
         compare_field("start_rejected", 8'(want.start_rejected),
                       8'(got.start_rejected));
         compare_field("padding", 8'd0,
                       8'(tdata[nectx_pkg::RSP_DATA_W-1:nectx_pkg::RESULT_W]));
         checked++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT signals and instance
   // -------------------------------------------------------------------------
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [15:0]                      req_tdata = '0;
   logic                             req_tuser = nectx_pkg::REQ_TICK;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [nectx_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             csr_we = 1'b0;
   logic [nectx_pkg::CSR_IDX_W-1:0]  csr_index = nectx_pkg::CSR_LEADER_MARK;
   logic [nectx_pkg::CFG_WIDTH-1:0]  csr_wdata = '0;

   nec_frame_scoreboard sb = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int settings       = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   nec_ir_frame_transmitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Result side: random backpressure and checking
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   task automatic send_request(input logic kind, input logic [15:0] payload);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= payload;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(kind, payload);
   endtask

   task automatic write_csr(input logic [nectx_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nectx_pkg::CFG_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.note_config(idx, value);
   endtask

   // all three lengths plus a write to the unmapped slot
   task automatic program_timing(input logic [nectx_pkg::CFG_WIDTH-1:0] mark, space,
                                 unit_len, spare);
      write_csr(nectx_pkg::CSR_LEADER_MARK, mark);
      write_csr(nectx_pkg::CSR_LEADER_SPACE, space);
      write_csr(nectx_pkg::CSR_UNIT, unit_len);
      write_csr(CSR_SPARE, spare);
      csr_we <= 1'b0;
      settings++;
   endtask

   // stop sending and wait for every expected result to arrive
   task automatic drain_results();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (sb.expected_q.size() != 0) begin
         $error("%0d results never arrived", sb.expected_q.size());
         sb.mismatches++;
      end
      repeat (3) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int   count;
      logic kind;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: largest lengths written while idle, never loaded
      program_timing(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_request(nectx_pkg::REQ_TICK, 16'hFFFF);
      send_request(nectx_pkg::REQ_TICK, 16'h0000);
      drain_results();
      // zero-length mark acts as one tick
      program_timing(24'd0, 24'd2, 24'd1, 24'd0);
      send_request(nectx_pkg::REQ_START, {8'h00, 8'hFF});
      send_request(nectx_pkg::REQ_START, 16'hA55A);
      repeat (6) send_request(nectx_pkg::REQ_TICK, 16'($urandom));
      drain_results();
      // unit length changed mid-frame, applies from the next interval
      program_timing(24'd0, 24'd2, 24'd2, 24'h5A5A5A);
      repeat (8) send_request(nectx_pkg::REQ_TICK, 16'($urandom));
      send_request(nectx_pkg::REQ_START, {8'hFF, 8'h00});
      repeat (4) send_request(nectx_pkg::REQ_TICK, 16'($urandom));

      // random phases, each with its own timing and idle pattern
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         if (p == 0)
            program_timing(24'd1, 24'd1, 24'd1, 24'($urandom));
         else if (p == 1)
            program_timing(24'd0, 24'd0, 24'd0, 24'($urandom));
         else
            program_timing(24'($urandom_range(24)), 24'($urandom_range(16)),
                           24'($urandom_range(2)), 24'($urandom));
         count = 0;
         while (count < ITEMS_PER_PHASE) begin
            if (sb.busy)
               kind = ($urandom_range(59) == 0) ? nectx_pkg::REQ_START
                                                : nectx_pkg::REQ_TICK;
            else
               kind = ($urandom_range(2) == 0) ? nectx_pkg::REQ_START
                                               : nectx_pkg::REQ_TICK;
            // ticks while idle change nothing, do not count them
            if (kind == nectx_pkg::REQ_START || sb.busy)
               count++;
            send_request(kind, 16'($urandom));
         end
      end

      drain_results();
      repeat (5) @(posedge clock);
      $display("Checked %0d results over %0d timing settings and four idle patterns.",
               sb.checked, settings);
      $display("Frames completed: %0d, starts rejected while busy: %0d.",
               sb.frames, sb.rejects);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #(3_000_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/nectx_pkg.sv
hw/rtl/nectx_engine.sv
hw/rtl/nec_ir_frame_transmitter.sv
tb/sv/tb.sv
